// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define ASSERT_OFF to drop
// them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/ucbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic B-spline evaluator package
// Field widths, stream packing offsets, operation codes and shared types.
// ----------------------------------------------------------------------------
package ucbs_pkg;

    localparam int COORD_W = 32;
    localparam int IDX_W   = 6;
    localparam int U_W     = 22;
    localparam int CNT_W   = 7;

    // Input tdata packing, lowest bit first
    localparam int IDX_LSB    = 0;
    localparam int X_LSB      = IDX_LSB + IDX_W;
    localparam int Y_LSB      = X_LSB + COORD_W;
    localparam int Z_LSB      = Y_LSB + COORD_W;
    localparam int U_LSB      = Z_LSB + COORD_W;
    localparam int IN_DATA_W  = U_LSB + U_W;
    localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;

    localparam int OUT_TDATA_W = 3 * COORD_W;

    // Operation codes carried in the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Element 0 is x, 1 is y, 2 is z
    typedef coord_t [2:0] point_t;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_FIRST,
        MODE_SPLINE
    } eval_mode_t;

endpackage

// ===== src/uniform_cubic_bspline_eval_top.sv =====
// ----------------------------------------------------------------------------
// Uniform cubic B-spline evaluator
// Holds up to MAX_POINTS 3-D control points in signed Q16.16 and evaluates a
// uniform cubic B-spline at a parameter u with FRAC_BITS fraction bits. A load
// transfer (tuser = 0) writes one point into the table and returns nothing; an
// evaluate transfer (tuser = 1) returns one position. u is clamped to the last
// valid segment; with no points the position is zero, with one to three points
// it is the first point, and spline_valid (output tuser) is set only when at
// least four points are in use. The block takes one transfer per clock while
// the output is not stalled; each evaluate passes through the ten-stage
// arithmetic pipeline (basis polynomial, divide-by-six, twelve
// weight-by-coordinate products, adder tree, rounding and saturation). The
// point table is split into four banks by index modulo four so that all four
// points of a segment are read in one cycle; a point loaded in one cycle is
// seen by an evaluate accepted in the next. point_count is written through
// cfg_we / cfg_wdata and must only change while no evaluate is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uniform_cubic_bspline_eval_top #(
    parameter int MAX_POINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: point_count
    input  logic                            cfg_we,
    input  logic [ucbs_pkg::CNT_W-1:0]      cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_index[5:0], coord_x[37:6], coord_y[69:38], coord_z[101:70],
    // u_param[123:102], zero [127:124]
    input  logic [ucbs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // operation[0]
    input  logic [0:0]                      s_axis_tuser,
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic [ucbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // spline_valid[0]
    output logic [0:0]                      m_axis_tuser
);

    import ucbs_pkg::*;

    // ------------------------------------------------------------------------
    // Derived widths and constants
    // ------------------------------------------------------------------------
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int BD    = (MAX_POINTS + 3) / 4;
    localparam int BAW   = (BD > 1) ? $clog2(BD) : 1;
    localparam int CEW   = (CNT_W > $clog2(MAX_POINTS + 1)) ? CNT_W : $clog2(MAX_POINTS + 1);
    localparam int UW    = AW + FRAC_BITS;
    localparam int CMPW  = (UW > U_W) ? UW : U_W;
    localparam int NW    = FRAC_BITS + 4;
    localparam int MW    = FRAC_BITS + 3;
    localparam int QW    = MW - 2;
    localparam int PRW   = MW + QW;
    localparam int WW    = FRAC_BITS + 2;
    localparam int PW    = WW + COORD_W;
    localparam int SW    = PW + 2;
    localparam int SHW   = SW - FRAC_BITS;
    localparam int NSTG  = 9;

    localparam int W_BIAS = 8;

    localparam logic [2*FRAC_BITS-1:0] HALF_SQ = (2*FRAC_BITS)'(1) << (FRAC_BITS - 1);
    localparam logic signed [NW-1:0]   ONE_N   = NW'(1) << FRAC_BITS;
    localparam logic signed [NW-1:0]   K3      = NW'(3);
    localparam logic signed [NW-1:0]   K4      = NW'(4);
    localparam logic signed [NW-1:0]   K6      = NW'(6);
    // +3 rounds to nearest, +6*W_BIAS keeps the dividend non-negative
    localparam logic signed [NW-1:0]   M_OFF   = NW'(3 + 6 * W_BIAS);
    localparam logic [QW-1:0]          RECIP6  = QW'((64'd1 << MW) / 64'd6);
    localparam logic signed [SW-1:0]   HALF_S  = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SHW-1:0]  SAT_HI  = SHW'(64'sd2147483647);
    localparam logic signed [SHW-1:0]  SAT_LO  = SHW'(-64'sd2147483648);

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    logic                 pipe_en;
    logic [CNT_W-1:0]     point_count_reg;
    logic [NSTG:1]        vld_reg;
    logic                 out_valid_reg;
    logic                 in_xfer;
    logic                 in_eval;

    assign pipe_en       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en;
    assign m_axis_tvalid = out_valid_reg;
    assign in_xfer       = s_axis_tvalid && pipe_en;
    assign in_eval       = in_xfer && (s_axis_tuser[0] == OP_EVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            vld_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                point_count_reg <= cfg_wdata;
            end
            if (pipe_en)
            begin
                vld_reg       <= {vld_reg[NSTG-1:1], in_eval};
                out_valid_reg <= vld_reg[NSTG];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: clamp u, pick segment and fraction
    // ------------------------------------------------------------------------
    logic [CEW-1:0]       cnt_eff;
    logic [AW-1:0]        seg_lim;
    logic [UW-1:0]        u_max;
    logic [U_W-1:0]       u_in;
    logic [UW-1:0]        u_cl;
    eval_mode_t           mode1_next;
    logic [AW-1:0]        seg1_next;
    logic [FRAC_BITS-1:0] t1_next;

    always_comb
    begin
        if (CEW'(point_count_reg) > CEW'(MAX_POINTS))
        begin
            cnt_eff = CEW'(MAX_POINTS);
        end
        else
        begin
            cnt_eff = CEW'(point_count_reg);
        end

        priority if (cnt_eff == '0)
        begin
            mode1_next = MODE_ZERO;
        end
        else if (cnt_eff < CEW'(4))
        begin
            mode1_next = MODE_FIRST;
        end
        else
        begin
            mode1_next = MODE_SPLINE;
        end

        seg_lim = AW'(cnt_eff - CEW'(3));
        u_max   = {seg_lim, {FRAC_BITS{1'b0}}} - UW'(1);
        u_in    = s_axis_tdata[U_LSB +: U_W];

        if (CMPW'(u_in) > CMPW'(u_max))
        begin
            u_cl = u_max;
        end
        else
        begin
            u_cl = UW'(u_in);
        end

        if (mode1_next == MODE_SPLINE)
        begin
            seg1_next = u_cl[UW-1:FRAC_BITS];
            t1_next   = u_cl[FRAC_BITS-1:0];
        end
        else
        begin
            // read entry 0 for the short-table case
            seg1_next = '0;
            t1_next   = '0;
        end
    end

    // ------------------------------------------------------------------------
    // Point table: four banks, entry i in bank i mod 4 at row i / 4
    // ------------------------------------------------------------------------
    logic             wr_en;
    logic [1:0]       wr_bank;
    logic [BAW-1:0]   wr_addr;
    point_t           wr_point;
    logic [BAW-1:0]   seg_hi1;
    point_t           bank_q_reg [0:3];

    logic                 [AW-1:0]        seg1_reg;
    eval_mode_t                           mode1_reg;
    logic                 [FRAC_BITS-1:0] t1_reg;

    assign wr_en    = in_xfer && (s_axis_tuser[0] == OP_LOAD)
                      && (32'(s_axis_tdata[IDX_LSB +: IDX_W]) < MAX_POINTS);
    assign wr_bank  = s_axis_tdata[IDX_LSB +: 2];
    assign wr_addr  = BAW'(s_axis_tdata[IDX_LSB +: IDX_W] >> 2);
    assign wr_point = {s_axis_tdata[Z_LSB +: COORD_W],
                       s_axis_tdata[Y_LSB +: COORD_W],
                       s_axis_tdata[X_LSB +: COORD_W]};
    assign seg_hi1  = BAW'(seg1_reg >> 2);

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        point_t         mem [0:BD-1];
        logic [BAW-1:0] rd_addr;

        // banks below the segment's start bank hold the wrapped points
        assign rd_addr = seg_hi1 + BAW'(2'(b) < seg1_reg[1:0]);

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(b)))
            begin
                mem[wr_addr] <= wr_point;
            end
            if (pipe_en)
            begin
                bank_q_reg[b] <= mem[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    logic [FRAC_BITS-1:0] t2_reg;
    logic [FRAC_BITS-1:0] t2_t_reg;
    logic [1:0]           seglo2_reg;
    eval_mode_t           mode2_reg;

    logic [FRAC_BITS-1:0] t3_t_reg;
    logic [FRAC_BITS-1:0] t3_t2_reg;
    logic [FRAC_BITS-1:0] t3_t3_reg;
    point_t               p3_reg [0:3];
    eval_mode_t           mode3_reg;

    logic [MW-1:0]        m4_reg [0:3];
    point_t               p4_reg [0:3];
    eval_mode_t           mode4_reg;

    logic [PRW-1:0]       prod5_reg [0:3];
    logic [MW-1:0]        m5_reg [0:3];
    point_t               p5_reg [0:3];
    eval_mode_t           mode5_reg;

    logic signed [WW-1:0] w6_reg [0:3];
    point_t               p6_reg [0:3];
    eval_mode_t           mode6_reg;

    logic signed [PW-1:0] pr7_reg [0:3][0:2];
    point_t               p0_7_reg;
    eval_mode_t           mode7_reg;

    logic signed [SW-1:0] a8_reg [0:2];
    logic signed [SW-1:0] b8_reg [0:2];
    point_t               p0_8_reg;
    eval_mode_t           mode8_reg;

    logic signed [SHW-1:0] sh9_reg [0:2];
    point_t                p0_9_reg;
    eval_mode_t            mode9_reg;

    point_t                pos_reg;
    logic                  flag_reg;

    // ------------------------------------------------------------------------
    // Combinational pieces between stages
    // ------------------------------------------------------------------------
    logic [2*FRAC_BITS-1:0] t2_full;
    logic [2*FRAC_BITS-1:0] t3_full;
    logic signed [NW-1:0]   tt;
    logic signed [NW-1:0]   tt2;
    logic signed [NW-1:0]   tt3;
    logic signed [NW-1:0]   n_val [0:3];
    logic [MW-1:0]          m4_next [0:3];
    logic [QW-1:0]          q_est [0:3];
    logic [MW:0]            rem [0:3];
    logic [QW-1:0]          q_fix [0:3];
    logic signed [WW-1:0]   w6_next [0:3];
    point_t                 pos_next;
    logic                   flag_next;

    assign t2_full = (2*FRAC_BITS)'(t1_reg) * (2*FRAC_BITS)'(t1_reg) + HALF_SQ;
    assign t3_full = (2*FRAC_BITS)'(t2_reg) * (2*FRAC_BITS)'(t2_t_reg) + HALF_SQ;

    // basis numerators at scale 2^FRAC_BITS, biased for the divide by six
    always_comb
    begin
        tt  = $signed(NW'(t3_t_reg));
        tt2 = $signed(NW'(t3_t2_reg));
        tt3 = $signed(NW'(t3_t3_reg));

        n_val[0] = ONE_N - tt3 + K3 * tt2 - K3 * tt;
        n_val[1] = K3 * tt3 - K6 * tt2 + K4 * ONE_N;
        n_val[2] = ONE_N - K3 * tt3 + K3 * tt2 + K3 * tt;
        n_val[3] = tt3;

        for (int k = 0; k < 4; k++)
        begin
            m4_next[k] = MW'(n_val[k] + M_OFF);
        end
    end

    // reciprocal estimate is low by at most one: correct with one compare
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            q_est[k]   = prod5_reg[k][PRW-1:MW];
            rem[k]     = (MW+1)'(m5_reg[k]) - (MW+1)'(q_est[k]) * (MW+1)'(6);
            q_fix[k]   = q_est[k] + QW'(rem[k] >= (MW+1)'(6));
            w6_next[k] = $signed(WW'(q_fix[k]) - WW'(W_BIAS));
        end
    end

    always_comb
    begin
        pos_next  = '0;
        flag_next = 1'b0;
        unique case (mode9_reg)
            MODE_ZERO:
            begin
                pos_next  = '0;
                flag_next = 1'b0;
            end
            MODE_FIRST:
            begin
                pos_next  = p0_9_reg;
                flag_next = 1'b0;
            end
            MODE_SPLINE:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (sh9_reg[c] > SAT_HI)
                    begin
                        pos_next[c] = SAT_HI[COORD_W-1:0];
                    end
                    else if (sh9_reg[c] < SAT_LO)
                    begin
                        pos_next[c] = SAT_LO[COORD_W-1:0];
                    end
                    else
                    begin
                        pos_next[c] = sh9_reg[c][COORD_W-1:0];
                    end
                end
                flag_next = 1'b1;
            end
            default:
            begin
                pos_next  = '0;
                flag_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipeline payload; all stages advance together and hold on a stall
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            // stage 1
            seg1_reg   <= seg1_next;
            t1_reg     <= t1_next;
            mode1_reg  <= mode1_next;

            // stage 2: t squared, bank read alongside
            t2_reg     <= t2_full[2*FRAC_BITS-1:FRAC_BITS];
            t2_t_reg   <= t1_reg;
            seglo2_reg <= seg1_reg[1:0];
            mode2_reg  <= mode1_reg;

            // stage 3: t cubed, put the points back in segment order
            t3_t_reg   <= t2_t_reg;
            t3_t2_reg  <= t2_reg;
            t3_t3_reg  <= t3_full[2*FRAC_BITS-1:FRAC_BITS];
            for (int k = 0; k < 4; k++)
            begin
                p3_reg[k] <= bank_q_reg[2'(seglo2_reg + 2'(k))];
            end
            mode3_reg  <= mode2_reg;

            // stage 4: numerators
            for (int k = 0; k < 4; k++)
            begin
                m4_reg[k] <= m4_next[k];
                p4_reg[k] <= p3_reg[k];
            end
            mode4_reg  <= mode3_reg;

            // stage 5: reciprocal multiply
            for (int k = 0; k < 4; k++)
            begin
                prod5_reg[k] <= PRW'(m4_reg[k]) * PRW'(RECIP6);
                m5_reg[k]    <= m4_reg[k];
                p5_reg[k]    <= p4_reg[k];
            end
            mode5_reg  <= mode4_reg;

            // stage 6: weights
            for (int k = 0; k < 4; k++)
            begin
                w6_reg[k] <= w6_next[k];
                p6_reg[k] <= p5_reg[k];
            end
            mode6_reg  <= mode5_reg;

            // stage 7: weight by coordinate
            for (int k = 0; k < 4; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pr7_reg[k][c] <= PW'(w6_reg[k] * $signed(p6_reg[k][c]));
                end
            end
            p0_7_reg   <= p6_reg[0];
            mode7_reg  <= mode6_reg;

            // stage 8: pair sums, rounding offset folded in
            for (int c = 0; c < 3; c++)
            begin
                a8_reg[c] <= SW'(pr7_reg[0][c]) + SW'(pr7_reg[1][c]);
                b8_reg[c] <= SW'(pr7_reg[2][c]) + SW'(pr7_reg[3][c]) + HALF_S;
            end
            p0_8_reg   <= p0_7_reg;
            mode8_reg  <= mode7_reg;

            // stage 9: final sum, back to Q16.16
            for (int c = 0; c < 3; c++)
            begin
                sh9_reg[c] <= SHW'((a8_reg[c] + b8_reg[c]) >>> FRAC_BITS);
            end
            p0_9_reg   <= p0_8_reg;
            mode9_reg  <= mode8_reg;

            // output register
            pos_reg    <= pos_next;
            flag_reg   <= flag_next;
        end
    end

    assign m_axis_tdata    = pos_reg;
    assign m_axis_tuser[0] = flag_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_NEXT(a_eval_enters, clk, rst_n, pipe_en, vld_reg[1] == $past(in_eval), "evaluate transfer did not enter the pipeline")
    `ASSERT_NEXT(a_valid_shift, clk, rst_n, pipe_en, vld_reg[NSTG:2] == $past(vld_reg[NSTG-1:1]), "valid bit lost or repeated between stages")
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, !pipe_en, m_axis_tvalid && $stable(vld_reg), "pipeline moved during a stall")
    `ASSERT_NOW(a_seg_range, clk, rst_n, mode1_next == MODE_SPLINE, 32'(seg1_next) + 32'd3 < 32'(cnt_eff), "clamped segment reaches past the last point")

endmodule
